// File: hdl/dsn_pkg.sv
// ----------------------------------------------------------------------------
// Depth surface normals package
// Shared sizes, configuration and job types, and state encodings.
// ----------------------------------------------------------------------------
package dsn_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int DIM_W       = 11;
    localparam int POS_W       = 10;
    localparam int SAMPLE_W    = 16;
    localparam int FOCAL_W     = 24;
    localparam int CFG_ADDR_W  = 4;
    localparam int CFG_DATA_W  = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        REG_IMAGE_WIDTH,
        REG_IMAGE_HEIGHT,
        REG_FOCAL_X,
        REG_FOCAL_Y
    } t_reg_idx;

    typedef struct packed {
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        logic [FOCAL_W-1:0] focal_x;
        logic [FOCAL_W-1:0] focal_y;
        logic               restart;
    } t_cfg;

    typedef struct packed {
        logic [SAMPLE_W-1:0] d11;
        logic [SAMPLE_W-1:0] d12;
        logic [SAMPLE_W-1:0] d21;
        logic [SAMPLE_W-1:0] d22;
        logic [POS_W-1:0]    row;
        logic [POS_W-1:0]    col;
        logic                frame_end;
    } t_job;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
    } t_qstat;

    typedef enum logic {
        F_IDLE,
        F_EMIT
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL,
        B_SQRT,
        B_DPREP,
        B_DIV,
        B_OUT
    } t_back_state;

endpackage

// File: hdl/dsn_in_if.sv
// ----------------------------------------------------------------------------
// Depth sample channel
// Valid/ready channel carrying one raw depth sample per word.
// ----------------------------------------------------------------------------
interface dsn_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] depth_sample;

    modport source (output valid, output depth_sample, input ready);
    modport sink (input valid, input depth_sample, output ready);
endinterface

// File: hdl/dsn_out_if.sv
// ----------------------------------------------------------------------------
// Surface normal channel
// Valid/ready channel carrying one Q1.15 unit normal and its pixel position.
// ----------------------------------------------------------------------------
interface dsn_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic               normal_valid;
    logic [9:0]         pixel_row;
    logic [9:0]         pixel_col;
    logic               frame_end;

    modport source (output valid, output normal_x, output normal_y, output normal_z,
                    output normal_valid, output pixel_row, output pixel_col,
                    output frame_end, input ready);
    modport sink (input valid, input normal_x, input normal_y, input normal_z,
                  input normal_valid, input pixel_row, input pixel_col,
                  input frame_end, output ready);
endinterface

// File: hdl/depth_surface_normals.sv
// ----------------------------------------------------------------------------
// Depth surface normals
// Streams raster depth samples and emits a Q1.15 unit normal per pixel from
// its 2x2 window, with an APB register port for frame size and focal lengths.
// ----------------------------------------------------------------------------
// A normal passes through the front end and queue, then the multiply, square root, divide
// and output states; a window with a zero sample goes straight to output. The back end
// takes a new job only once the last normal has been handed on; the front end takes a new
// sample only after all the jobs of the last one have gone into the queue.
// Reset (synchronous, active low) clears position, queue and back end state and loads
// 640x480 at focal length 520.0; the line buffer is written in a frame before it is read.
module depth_surface_normals (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    dsn_in_if.sink                          i_depth,
    dsn_out_if.source                       o_normal,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [dsn_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [dsn_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [dsn_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready
);

    logic [dsn_pkg::DIM_W-1:0]   r_width;
    logic [dsn_pkg::DIM_W-1:0]   r_height;
    logic [dsn_pkg::FOCAL_W-1:0] r_focal_x;
    logic [dsn_pkg::FOCAL_W-1:0] r_focal_y;
    logic                        wr_en;
    dsn_pkg::t_reg_idx           reg_idx;
    dsn_pkg::t_cfg               cfg;
    dsn_pkg::t_job               front_job;
    logic                        front_valid;
    logic                        front_ready;
    dsn_pkg::t_job               back_job;
    logic                        back_valid;
    logic                        back_ready;
    dsn_pkg::t_qstat             qstat;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = dsn_pkg::t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= dsn_pkg::DIM_W'(640);
            r_height <= dsn_pkg::DIM_W'(480);
            r_focal_x <= dsn_pkg::FOCAL_W'(133120);
            r_focal_y <= dsn_pkg::FOCAL_W'(133120);
        end else begin
            if (wr_en) begin
                case (reg_idx)
                    dsn_pkg::REG_IMAGE_WIDTH: begin
                        r_width <= pwdata[dsn_pkg::DIM_W-1:0];
                    end
                    dsn_pkg::REG_IMAGE_HEIGHT: begin
                        r_height <= pwdata[dsn_pkg::DIM_W-1:0];
                    end
                    dsn_pkg::REG_FOCAL_X: begin
                        r_focal_x <= pwdata[dsn_pkg::FOCAL_W-1:0];
                    end
                    dsn_pkg::REG_FOCAL_Y: begin
                        r_focal_y <= pwdata[dsn_pkg::FOCAL_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_comb begin
        case (reg_idx)
            dsn_pkg::REG_IMAGE_WIDTH:  prdata = dsn_pkg::CFG_DATA_W'(r_width);
            dsn_pkg::REG_IMAGE_HEIGHT: prdata = dsn_pkg::CFG_DATA_W'(r_height);
            dsn_pkg::REG_FOCAL_X:      prdata = dsn_pkg::CFG_DATA_W'(r_focal_x);
            dsn_pkg::REG_FOCAL_Y:      prdata = dsn_pkg::CFG_DATA_W'(r_focal_y);
            default:                   prdata = '0;
        endcase
    end

    // Sizes are used clamped to the supported frame. A size write restarts the
    // frame at the same edge, so a sample right after it starts the new frame.
    always_comb begin
        if (r_width < dsn_pkg::DIM_W'(2)) begin
            cfg.width = dsn_pkg::DIM_W'(2);
        end else if (r_width > dsn_pkg::DIM_W'(dsn_pkg::MAX_WIDTH)) begin
            cfg.width = dsn_pkg::DIM_W'(dsn_pkg::MAX_WIDTH);
        end else begin
            cfg.width = r_width;
        end
        if (r_height < dsn_pkg::DIM_W'(2)) begin
            cfg.height = dsn_pkg::DIM_W'(2);
        end else if (r_height > dsn_pkg::DIM_W'(dsn_pkg::MAX_HEIGHT)) begin
            cfg.height = dsn_pkg::DIM_W'(dsn_pkg::MAX_HEIGHT);
        end else begin
            cfg.height = r_height;
        end
        cfg.focal_x = r_focal_x;
        cfg.focal_y = r_focal_y;
        cfg.restart = wr_en && ((reg_idx == dsn_pkg::REG_IMAGE_WIDTH) ||
                                (reg_idx == dsn_pkg::REG_IMAGE_HEIGHT));
    end

    dsn_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_depth     (i_depth),
        .o_job       (front_job),
        .o_job_valid (front_valid),
        .i_job_ready (front_ready)
    );

    dsn_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_data  (front_job),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .o_pop_data   (back_job),
        .o_pop_valid  (back_valid),
        .i_pop_ready  (back_ready),
        .o_stat       (qstat)
    );

    dsn_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_job       (back_job),
        .i_job_valid (back_valid),
        .o_job_ready (back_ready),
        .o_normal    (o_normal)
    );

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_normal.valid && !o_normal.normal_valid) |->
        (o_normal.normal_x == 16'sd0 && o_normal.normal_y == 16'sd0 &&
         o_normal.normal_z == 16'sd0))
        else $error("invalid window gave a nonzero normal");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        qstat.count <= dsn_pkg::QCNT_W'(dsn_pkg::QUEUE_DEPTH))
        else $error("job queue count beyond its depth");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_normal.valid)
        else $error("normal word offered right after reset");

endmodule

// File: hdl/dsn_front.sv
// ----------------------------------------------------------------------------
// Depth surface normals front end
// Accepts samples, keeps the line buffer and raster position, and turns each
// sample into the 2x2 window jobs that it completes.
// ----------------------------------------------------------------------------
module dsn_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dsn_pkg::t_cfg     i_cfg,
    dsn_in_if.sink            i_depth,
    output dsn_pkg::t_job     o_job,
    output logic              o_job_valid,
    input  logic              i_job_ready
);

    logic [dsn_pkg::SAMPLE_W-1:0] r_line [dsn_pkg::MAX_WIDTH];
    logic [dsn_pkg::SAMPLE_W-1:0] r_above;
    logic [dsn_pkg::SAMPLE_W-1:0] r_cur;
    logic [dsn_pkg::SAMPLE_W-1:0] r_left;
    logic [dsn_pkg::SAMPLE_W-1:0] r_al;
    logic [dsn_pkg::COL_W-1:0]    r_col;
    logic [dsn_pkg::ROW_W-1:0]    r_row;
    logic [dsn_pkg::COL_W-1:0]    r_x;
    logic [dsn_pkg::ROW_W-1:0]    r_y;
    logic [3:0]                   r_mask;
    logic [3:0]                   n_mask;
    dsn_pkg::t_front_state        r_state;
    dsn_pkg::t_front_state        n_state;

    logic                         accept;
    logic                         wrap;
    logic [dsn_pkg::COL_W-1:0]    x;
    logic [dsn_pkg::ROW_W-1:0]    y;
    logic                         last_row;
    logic                         last_col;
    logic                         push;
    logic [dsn_pkg::DIM_W-1:0]    next_x;
    logic [dsn_pkg::DIM_W-1:0]    next_y;

    assign i_depth.ready = (r_state == dsn_pkg::F_IDLE);
    assign accept        = i_depth.valid && i_depth.ready;

    // A size change may leave the position outside the frame; start over then.
    assign wrap = ({1'b0, r_col} >= i_cfg.width) || ({1'b0, r_row} >= i_cfg.height);
    assign x    = wrap ? '0 : r_col;
    assign y    = wrap ? '0 : r_row;
    assign last_row = ({1'b0, y} == i_cfg.height - 1'b1);
    assign last_col = ({1'b0, x} == i_cfg.width - 1'b1);

    assign next_x = {1'b0, r_x} + 1'b1;
    assign next_y = {1'b0, r_y} + 1'b1;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_above <= r_line[x];
            r_line[x] <= i_depth.depth_sample;
            r_cur <= i_depth.depth_sample;
            r_x <= x;
            r_y <= y;
        end
    end

    // Windows in release order: above-left pixel, above pixel at the right
    // edge, left pixel in the last row, and the bottom-right pixel itself.
    always_comb begin
        o_job = '0;
        if (r_mask[0]) begin
            o_job.d11 = r_al;
            o_job.d12 = r_above;
            o_job.d21 = r_left;
            o_job.d22 = r_cur;
            o_job.row = dsn_pkg::POS_W'(r_y - 1'b1);
            o_job.col = dsn_pkg::POS_W'(r_x - 1'b1);
        end else if (r_mask[1]) begin
            o_job.d11 = r_above;
            o_job.d12 = r_above;
            o_job.d21 = r_cur;
            o_job.d22 = r_cur;
            o_job.row = dsn_pkg::POS_W'(r_y - 1'b1);
            o_job.col = dsn_pkg::POS_W'(r_x);
        end else if (r_mask[2]) begin
            o_job.d11 = r_left;
            o_job.d12 = r_cur;
            o_job.d21 = r_left;
            o_job.d22 = r_cur;
            o_job.row = dsn_pkg::POS_W'(r_y);
            o_job.col = dsn_pkg::POS_W'(r_x - 1'b1);
        end else begin
            o_job.d11 = r_cur;
            o_job.d12 = r_cur;
            o_job.d21 = r_cur;
            o_job.d22 = r_cur;
            o_job.row = dsn_pkg::POS_W'(r_y);
            o_job.col = dsn_pkg::POS_W'(r_x);
            o_job.frame_end = 1'b1;
        end
    end

    assign o_job_valid = (r_state == dsn_pkg::F_EMIT) && (r_mask != '0);
    assign push        = o_job_valid && i_job_ready;

    always_comb begin
        n_state = r_state;
        n_mask  = r_mask;
        case (r_state)
            dsn_pkg::F_IDLE: begin
                if (accept) begin
                    n_mask[0] = (y != '0) && (x != '0);
                    n_mask[1] = (y != '0) && last_col;
                    n_mask[2] = (y != '0) && last_row && (x != '0);
                    n_mask[3] = (y != '0) && last_row && last_col;
                    n_state = dsn_pkg::F_EMIT;
                end
            end
            dsn_pkg::F_EMIT: begin
                if (push) begin
                    n_mask = r_mask & (r_mask - 1'b1);
                end
                if (r_mask == '0) begin
                    n_state = dsn_pkg::F_IDLE;
                end
            end
            default: begin
                n_state = dsn_pkg::F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dsn_pkg::F_IDLE;
            r_mask <= '0;
            r_col <= '0;
            r_row <= '0;
            r_left <= '0;
            r_al <= '0;
        end else if (i_cfg.restart) begin
            r_state <= dsn_pkg::F_IDLE;
            r_mask <= '0;
            r_col <= '0;
            r_row <= '0;
            r_left <= '0;
            r_al <= '0;
        end else begin
            r_state <= n_state;
            r_mask <= n_mask;
            if (r_state == dsn_pkg::F_EMIT && r_mask == '0) begin
                r_al <= r_above;
                r_left <= r_cur;
                if (next_x >= i_cfg.width) begin
                    r_col <= '0;
                    r_row <= (next_y >= i_cfg.height) ? '0 : dsn_pkg::ROW_W'(next_y);
                end else begin
                    r_col <= dsn_pkg::COL_W'(next_x);
                    r_row <= r_y;
                end
            end
        end
    end

endmodule

// File: hdl/dsn_queue.sv
// ----------------------------------------------------------------------------
// Depth surface normals job queue
// Small FIFO of window jobs between the front end and the arithmetic back end.
// ----------------------------------------------------------------------------
module dsn_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  dsn_pkg::t_job   i_push_data,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    output dsn_pkg::t_job   o_pop_data,
    output logic            o_pop_valid,
    input  logic            i_pop_ready,
    output dsn_pkg::t_qstat o_stat
);

    dsn_pkg::t_job               r_mem [dsn_pkg::QUEUE_DEPTH];
    logic [dsn_pkg::QPTR_W-1:0]  r_wptr;
    logic [dsn_pkg::QPTR_W-1:0]  r_rptr;
    logic [dsn_pkg::QCNT_W-1:0]  r_count;
    logic                        push;
    logic                        pop;

    assign o_push_ready = (r_count != dsn_pkg::QCNT_W'(dsn_pkg::QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_stat.count = r_count;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: hdl/dsn_back.sv
// ----------------------------------------------------------------------------
// Depth surface normals back end
// Computes one unit normal per job, or a zero word where a sample is zero: a
// shared 24x24 multiplier builds the squared length, a bit-serial square root
// finds its magnitude, and three bit-serial dividers scale each component to Q1.15.
// ----------------------------------------------------------------------------
module dsn_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  dsn_pkg::t_cfg i_cfg,
    input  dsn_pkg::t_job i_job,
    input  logic          i_job_valid,
    output logic          o_job_ready,
    dsn_out_if.source     o_normal
);

    localparam int MAG_W   = 41;
    localparam int CZ_W    = 25;
    localparam int ACC_W   = 84;
    localparam int ROOT_W  = 42;
    localparam int REM_W   = 44;
    localparam int NUM_W   = 57;
    localparam int Q_W     = 16;
    localparam int SPLIT   = 21;
    localparam int OPND_W  = 24;

    localparam logic [3:0] ST_AX   = 4'd0;
    localparam logic [3:0] ST_AY   = 4'd1;
    localparam logic [3:0] ST_AX0  = 4'd2;
    localparam logic [3:0] ST_AX1  = 4'd3;
    localparam logic [3:0] ST_AX2  = 4'd4;
    localparam logic [3:0] ST_CZ0  = 4'd5;
    localparam logic [3:0] ST_CZ1  = 4'd6;
    localparam logic [3:0] ST_CZ2  = 4'd7;
    localparam logic [3:0] ST_AY0  = 4'd8;
    localparam logic [3:0] ST_AY1  = 4'd9;
    localparam logic [3:0] ST_AY2  = 4'd10;
    localparam logic [3:0] ST_LAST = 4'd11;

    localparam logic [5:0] SQRT_LAST = 6'(ROOT_W - 1);
    localparam logic [5:0] DIV_LAST  = 6'(Q_W - 1);

    dsn_pkg::t_back_state r_state;
    dsn_pkg::t_back_state n_state;

    logic [dsn_pkg::POS_W-1:0] r_row;
    logic [dsn_pkg::POS_W-1:0] r_col;
    logic                      r_end;
    logic                      r_nv;
    logic                      r_negx;
    logic                      r_negy;
    logic [16:0]               r_adx;
    logic [16:0]               r_ady;
    logic [CZ_W-1:0]           r_cz;
    logic [MAG_W-1:0]          r_ax;
    logic [MAG_W-1:0]          r_ay;
    logic [2*OPND_W-1:0]       r_prod;
    logic [6:0]                r_psh;
    logic [3:0]                r_pk;
    logic                      r_pv;
    logic [3:0]                r_step;
    logic [ACC_W-1:0]          r_acc;
    logic [REM_W-1:0]          r_srem;
    logic [ROOT_W-1:0]         r_m;
    logic [5:0]                r_cnt;
    logic [ROOT_W-1:0]         r_dr [3];
    logic [Q_W-1:0]            r_dl [3];
    logic [Q_W-1:0]            r_q [3];

    logic                      take;
    logic                      all_nz;
    logic signed [18:0]        dx;
    logic signed [18:0]        dy;
    logic [17:0]               sum;
    logic [OPND_W-1:0]         opa;
    logic [OPND_W-1:0]         opb;
    logic [6:0]                shamt;
    logic [REM_W+1:0]          sq_w;
    logic [REM_W+1:0]          sq_t;
    logic                      sq_ge;
    logic [MAG_W-1:0]          mag [3];
    logic [NUM_W-1:0]          num [3];

    function automatic logic signed [15:0] to_q15(input logic [Q_W-1:0] q, input logic neg);
        logic [16:0] m17;
        m17 = (q > 16'd32768) ? 17'd32768 : {1'b0, q};
        if (neg) begin
            return 16'(17'h10000 - m17);
        end
        return (q > 16'd32767) ? 16'sd32767 : q;
    endfunction

    assign take   = (r_state == dsn_pkg::B_IDLE) && i_job_valid;
    assign o_job_ready = (r_state == dsn_pkg::B_IDLE);
    assign all_nz = (i_job.d11 != '0) && (i_job.d12 != '0) &&
                    (i_job.d21 != '0) && (i_job.d22 != '0);
    assign dx  = 19'(i_job.d12) + 19'(i_job.d22) - 19'(i_job.d21) - 19'(i_job.d11);
    assign dy  = 19'(i_job.d21) + 19'(i_job.d22) - 19'(i_job.d12) - 19'(i_job.d11);
    assign sum = 18'(i_job.d11) + 18'(i_job.d12) + 18'(i_job.d21) + 18'(i_job.d22);

    // Each square is split at bit 21 into high*high, doubled cross and low*low.
    always_comb begin
        opa = '0;
        opb = '0;
        shamt = '0;
        case (r_step)
            ST_AX: begin
                opa = OPND_W'(r_adx);
                opb = i_cfg.focal_x;
            end
            ST_AY: begin
                opa = OPND_W'(r_ady);
                opb = i_cfg.focal_y;
            end
            ST_AX0: begin
                opa = OPND_W'(r_ax[SPLIT-1:0]);
                opb = OPND_W'(r_ax[SPLIT-1:0]);
            end
            ST_AX1: begin
                opa = OPND_W'(r_ax[MAG_W-1:SPLIT]);
                opb = OPND_W'(r_ax[SPLIT-1:0]);
                shamt = 7'(SPLIT + 1);
            end
            ST_AX2: begin
                opa = OPND_W'(r_ax[MAG_W-1:SPLIT]);
                opb = OPND_W'(r_ax[MAG_W-1:SPLIT]);
                shamt = 7'(2 * SPLIT);
            end
            ST_CZ0: begin
                opa = OPND_W'(r_cz[SPLIT-1:0]);
                opb = OPND_W'(r_cz[SPLIT-1:0]);
            end
            ST_CZ1: begin
                opa = OPND_W'(r_cz[CZ_W-1:SPLIT]);
                opb = OPND_W'(r_cz[SPLIT-1:0]);
                shamt = 7'(SPLIT + 1);
            end
            ST_CZ2: begin
                opa = OPND_W'(r_cz[CZ_W-1:SPLIT]);
                opb = OPND_W'(r_cz[CZ_W-1:SPLIT]);
                shamt = 7'(2 * SPLIT);
            end
            ST_AY0: begin
                opa = OPND_W'(r_ay[SPLIT-1:0]);
                opb = OPND_W'(r_ay[SPLIT-1:0]);
            end
            ST_AY1: begin
                opa = OPND_W'(r_ay[MAG_W-1:SPLIT]);
                opb = OPND_W'(r_ay[SPLIT-1:0]);
                shamt = 7'(SPLIT + 1);
            end
            ST_AY2: begin
                opa = OPND_W'(r_ay[MAG_W-1:SPLIT]);
                opb = OPND_W'(r_ay[MAG_W-1:SPLIT]);
                shamt = 7'(2 * SPLIT);
            end
            default: begin
                opa = '0;
                opb = '0;
            end
        endcase
    end

    assign sq_w  = {r_srem, r_acc[ACC_W-1:ACC_W-2]};
    assign sq_t  = (REM_W + 2)'({r_m, 2'b01});
    assign sq_ge = (sq_w >= sq_t);

    assign mag[0] = r_ax;
    assign mag[1] = r_ay;
    assign mag[2] = MAG_W'(r_cz);

    // Numerator of round(v * 32768 / m): v shifted up plus half the divisor.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            num[i] = NUM_W'({mag[i], 15'b0}) + NUM_W'(r_m[ROOT_W-1:1]);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            dsn_pkg::B_IDLE: begin
                if (take) begin
                    n_state = all_nz ? dsn_pkg::B_MUL : dsn_pkg::B_OUT;
                end
            end
            dsn_pkg::B_MUL: begin
                if (r_step == ST_LAST) begin
                    n_state = dsn_pkg::B_SQRT;
                end
            end
            dsn_pkg::B_SQRT: begin
                if (r_cnt == SQRT_LAST) begin
                    n_state = dsn_pkg::B_DPREP;
                end
            end
            dsn_pkg::B_DPREP: begin
                n_state = dsn_pkg::B_DIV;
            end
            dsn_pkg::B_DIV: begin
                if (r_cnt == DIV_LAST) begin
                    n_state = dsn_pkg::B_OUT;
                end
            end
            dsn_pkg::B_OUT: begin
                if (o_normal.ready) begin
                    n_state = dsn_pkg::B_IDLE;
                end
            end
            default: begin
                n_state = dsn_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dsn_pkg::B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            dsn_pkg::B_IDLE: begin
                r_row <= i_job.row;
                r_col <= i_job.col;
                r_end <= i_job.frame_end;
                r_nv <= all_nz;
                r_negx <= all_nz && (dx > 0);
                r_negy <= all_nz && (dy > 0);
                r_adx <= 17'((dx < 0) ? -dx : dx);
                r_ady <= 17'((dy < 0) ? -dy : dy);
                r_cz <= {sum, 7'b0};
                r_step <= ST_AX;
                r_pv <= 1'b0;
                r_acc <= '0;
                for (int i = 0; i < 3; i++) begin
                    r_q[i] <= '0;
                end
            end
            dsn_pkg::B_MUL: begin
                r_prod <= opa * opb;
                r_psh <= shamt;
                r_pk <= r_step;
                r_pv <= 1'b1;
                r_step <= r_step + 1'b1;
                if (r_pv) begin
                    if (r_pk == ST_AX) begin
                        r_ax <= r_prod[MAG_W-1:0];
                    end else if (r_pk == ST_AY) begin
                        r_ay <= r_prod[MAG_W-1:0];
                    end else begin
                        r_acc <= r_acc + (ACC_W'(r_prod) << r_psh);
                    end
                end
                r_srem <= '0;
                r_m <= '0;
                r_cnt <= '0;
            end
            dsn_pkg::B_SQRT: begin
                r_srem <= sq_ge ? REM_W'(sq_w - sq_t) : sq_w[REM_W-1:0];
                r_m <= {r_m[ROOT_W-2:0], sq_ge};
                r_acc <= r_acc << 2;
                r_cnt <= r_cnt + 1'b1;
            end
            dsn_pkg::B_DPREP: begin
                for (int i = 0; i < 3; i++) begin
                    r_dr[i] <= ROOT_W'(num[i][NUM_W-1:Q_W]);
                    r_dl[i] <= num[i][Q_W-1:0];
                end
                r_cnt <= '0;
            end
            dsn_pkg::B_DIV: begin
                for (int i = 0; i < 3; i++) begin
                    if ({r_dr[i], r_dl[i][Q_W-1]} >= {1'b0, r_m}) begin
                        r_dr[i] <= ROOT_W'({r_dr[i], r_dl[i][Q_W-1]} - {1'b0, r_m});
                        r_q[i] <= {r_q[i][Q_W-2:0], 1'b1};
                    end else begin
                        r_dr[i] <= {r_dr[i][ROOT_W-2:0], r_dl[i][Q_W-1]};
                        r_q[i] <= {r_q[i][Q_W-2:0], 1'b0};
                    end
                    r_dl[i] <= r_dl[i] << 1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
            default: begin
                r_pv <= 1'b0;
            end
        endcase
    end

    assign o_normal.valid        = (r_state == dsn_pkg::B_OUT);
    assign o_normal.normal_x     = to_q15(r_q[0], r_negx);
    assign o_normal.normal_y     = to_q15(r_q[1], r_negy);
    assign o_normal.normal_z     = to_q15(r_q[2], 1'b0);
    assign o_normal.normal_valid = r_nv;
    assign o_normal.pixel_row    = r_row;
    assign o_normal.pixel_col    = r_col;
    assign o_normal.frame_end    = r_end;

endmodule

// File: tb/depth_surface_normals_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depth surface normals testbench
// Streams depth frames of many sizes and focal lengths into the block, with
// random gaps on both channels, and checks every normal, field by field,
// against a fixed-point predictor of the 2x2 window computation.
// ----------------------------------------------------------------------------
module depth_surface_normals_test;

    localparam int SETTLE_CYCLES = 400;
    localparam int HOLD_CYCLES   = 600;
    localparam int STALL_LIMIT   = 5000;
    localparam int EXP_DEPTH     = 1024;

    typedef enum {CHK_MODEL, CHK_FLAT, CHK_HOLE} t_chk;

    typedef struct {
        logic [15:0] sample;
        t_chk        chk;
    } t_row;

    typedef struct {
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic               ok;
        logic [9:0]         row;
        logic [9:0]         col;
        logic               fin;
    } t_normal;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [dsn_pkg::CFG_ADDR_W-1:0] paddr = '0;
    logic [dsn_pkg::CFG_DATA_W-1:0] pwdata = '0;
    logic [dsn_pkg::CFG_DATA_W-1:0] prdata;
    logic pready;

    dsn_in_if  depth_ch ();
    dsn_out_if normal_ch ();

    depth_surface_normals dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_depth(depth_ch.sink),
        .o_normal(normal_ch.source), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        depth_ch.valid = 1'b0;
        depth_ch.depth_sample = '0;
        normal_ch.ready = 1'b0;
    end

    // Predictor state and configuration.
    logic [15:0] line_buf [dsn_pkg::MAX_WIDTH];
    logic [15:0] left_s, above_left_s;
    int          row_pos, col_pos;
    logic [10:0] cfg_w, cfg_h;
    logic [23:0] cfg_fx, cfg_fy;

    // Expected normals in order, as a ring with write and read counts.
    t_normal expected_buf [EXP_DEPTH];
    int      exp_wr = 0, exp_rd = 0;
    int      errors = 0;
    int      samples_sent = 0, normals_seen = 0, valid_normals = 0, frames_seen = 0;
    bit      no_idle = 1'b0;
    bit      hold_req = 1'b0;

    function automatic logic [15:0] to_q15(logic [127:0] mag, bit neg, logic [127:0] m);
        logic [127:0] q;
        q = (mag * 32768 + m / 2) / m;
        if (neg) begin
            if (q > 32768) q = 32768;
            return 16'(17'h10000 - q[16:0]);
        end
        if (q > 32767) q = 32767;
        return q[15:0];
    endfunction

    function automatic t_normal window_normal(int d11, int d12, int d21, int d22,
                                              int r, int c, bit fin);
        t_normal n;
        longint dx, dy;
        logic [127:0] ax, ay, cz, sum_sq, t, m;
        n = '{nx: 0, ny: 0, nz: 0, ok: 0, row: 10'(r), col: 10'(c), fin: fin};
        if (d11 != 0 && d12 != 0 && d21 != 0 && d22 != 0) begin
            dx = longint'(d12) + d22 - d21 - d11;
            dy = longint'(d21) + d22 - d12 - d11;
            ax = 128'(dx < 0 ? -dx : dx) * cfg_fx;
            ay = 128'(dy < 0 ? -dy : dy) * cfg_fy;
            cz = 128'(128) * (d11 + d12 + d21 + d22);
            sum_sq = ax * ax + ay * ay + cz * cz;
            m = 0;
            for (int i = 63; i >= 0; i--) begin
                t = m | (128'(1) << i);
                if (t * t <= sum_sq) m = t;
            end
            n.nx = to_q15(ax, dx > 0, m);
            n.ny = to_q15(ay, dy > 0, m);
            n.nz = to_q15(cz, 1'b0, m);
            n.ok = 1'b1;
        end
        return n;
    endfunction

    function automatic void restart_frame();
        row_pos = 0;
        col_pos = 0;
        left_s = 0;
        above_left_s = 0;
    endfunction

    function automatic void queue_normal(t_normal n, t_chk chk);
        if (chk == CHK_FLAT) begin
            n.nx = 0; n.ny = 0; n.nz = 16'sd32767; n.ok = 1'b1;
        end else if (chk == CHK_HOLE) begin
            n.nx = 0; n.ny = 0; n.nz = 0; n.ok = 1'b0;
        end
        expected_buf[exp_wr % EXP_DEPTH] = n;
        exp_wr++;
    endfunction

    // Works out the normals that one accepted sample releases.
    function automatic void predict_sample(logic [15:0] cur, t_chk chk);
        int w, h, x, y;
        logic [15:0] above, al, left;
        bit last_row, last_col;
        w = cfg_w < 2 ? 2 : (cfg_w > dsn_pkg::MAX_WIDTH ? dsn_pkg::MAX_WIDTH : cfg_w);
        h = cfg_h < 2 ? 2 : (cfg_h > dsn_pkg::MAX_HEIGHT ? dsn_pkg::MAX_HEIGHT : cfg_h);
        if (col_pos >= w || row_pos >= h) restart_frame();
        x = col_pos;
        y = row_pos;
        above = line_buf[x];
        al = above_left_s;
        left = left_s;
        if (y >= 1) begin
            last_row = (y == h - 1);
            last_col = (x == w - 1);
            if (x >= 1)
                queue_normal(window_normal(al, above, left, cur, y - 1, x - 1, 0), chk);
            if (last_col)
                queue_normal(window_normal(above, above, cur, cur, y - 1, x, 0), chk);
            if (last_row && x >= 1)
                queue_normal(window_normal(left, cur, left, cur, y, x - 1, 0), chk);
            if (last_row && last_col)
                queue_normal(window_normal(cur, cur, cur, cur, y, x, 1), chk);
        end
        above_left_s = above;
        left_s = cur;
        line_buf[x] = cur;
        x++;
        if (x >= w) begin
            x = 0;
            y++;
            if (y >= h) y = 0;
        end
        col_pos = x;
        row_pos = y;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        errors++;
        $display("mismatch at %0t: %s got %0d, expected %0d", $realtime, field, got, want);
    endtask

    task automatic write_reg(dsn_pkg::t_reg_idx idx, logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= dsn_pkg::CFG_ADDR_W'(idx) << 2;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            dsn_pkg::REG_IMAGE_WIDTH: begin
                cfg_w = value[10:0];
                restart_frame();
            end
            dsn_pkg::REG_IMAGE_HEIGHT: begin
                cfg_h = value[10:0];
                restart_frame();
            end
            dsn_pkg::REG_FOCAL_X: cfg_fx = value[23:0];
            dsn_pkg::REG_FOCAL_Y: cfg_fy = value[23:0];
            default: ;
        endcase
    endtask

    // The block may still be busy after the last normal, so give it time.
    task automatic wait_idle();
        while (exp_wr != exp_rd) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_sample(logic [15:0] sample, t_chk chk);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            depth_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        depth_ch.valid <= 1'b1;
        depth_ch.depth_sample <= sample;
        do @(posedge i_clk); while (!depth_ch.ready);
        samples_sent++;
        predict_sample(sample, chk);
    endtask

    task automatic end_burst();
        depth_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_depth();
        return ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
    endfunction

    function automatic logic [23:0] rand_focal();
        case ($urandom_range(0, 5))
            0: return 24'd1;
            1: return 24'hFFFFFF;
            default: return 24'($urandom_range(256, 400000));
        endcase
    endfunction

    // Receiver: random stalls, and one long hold-off on request.
    always begin
        int wait_n;
        if (hold_req) begin
            normal_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            hold_req = 1'b0;
        end
        wait_n = no_idle ? 0 : $urandom_range(0, 12);
        if (wait_n > 0) begin
            normal_ch.ready <= 1'b0;
            repeat (wait_n) @(posedge i_clk);
        end
        normal_ch.ready <= 1'b1;
        do @(posedge i_clk); while (!(normal_ch.valid && i_rst_n));
    end

    always @(posedge i_clk) begin
        t_normal want;
        if (i_rst_n && normal_ch.valid && normal_ch.ready) begin
            normals_seen++;
            if (exp_wr == exp_rd) begin
                report_mismatch("unexpected normal at col", normal_ch.pixel_col, -1);
            end else begin
                want = expected_buf[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (normal_ch.normal_x !== want.nx)
                    report_mismatch("normal_x", normal_ch.normal_x, want.nx);
                if (normal_ch.normal_y !== want.ny)
                    report_mismatch("normal_y", normal_ch.normal_y, want.ny);
                if (normal_ch.normal_z !== want.nz)
                    report_mismatch("normal_z", normal_ch.normal_z, want.nz);
                if (normal_ch.normal_valid !== want.ok)
                    report_mismatch("normal_valid", normal_ch.normal_valid, want.ok);
                if (normal_ch.pixel_row !== want.row)
                    report_mismatch("pixel_row", normal_ch.pixel_row, want.row);
                if (normal_ch.pixel_col !== want.col)
                    report_mismatch("pixel_col", normal_ch.pixel_col, want.col);
                if (normal_ch.frame_end !== want.fin)
                    report_mismatch("frame_end", normal_ch.frame_end, want.fin);
                if (want.ok) valid_normals++;
                if (want.fin) frames_seen++;
            end
        end
    end

    // Watchdog on cycles without any word or register write moving.
    always @(posedge i_clk) begin
        int quiet;
        if ((depth_ch.valid && depth_ch.ready) || (normal_ch.valid && normal_ch.ready)
            || psel || !i_rst_n)
            quiet = 0;
        else
            quiet++;
        if (quiet >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    t_row directed [24] = '{
        '{16'd100, CHK_FLAT}, '{16'd100, CHK_FLAT}, '{16'd100, CHK_FLAT},
        '{16'd100, CHK_FLAT},
        '{16'd65535, CHK_FLAT}, '{16'd65535, CHK_FLAT}, '{16'd65535, CHK_FLAT},
        '{16'd65535, CHK_FLAT},
        '{16'd0, CHK_HOLE}, '{16'd0, CHK_HOLE}, '{16'd0, CHK_HOLE}, '{16'd0, CHK_HOLE},
        '{16'd1, CHK_MODEL}, '{16'd65535, CHK_MODEL}, '{16'd1, CHK_MODEL},
        '{16'd65535, CHK_MODEL},
        '{16'd1, CHK_MODEL}, '{16'd1, CHK_MODEL}, '{16'd65535, CHK_MODEL},
        '{16'd65535, CHK_MODEL},
        '{16'd0, CHK_MODEL}, '{16'd7, CHK_MODEL}, '{16'd9, CHK_MODEL},
        '{16'd3, CHK_MODEL}
    };

    initial begin
        int w, h, n, phase;
        cfg_w = 11'd640;
        cfg_h = 11'd480;
        cfg_fx = 24'd133120;
        cfg_fy = 24'd133120;
        restart_frame();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed frames of 2x2 at the reset focal lengths.
        write_reg(dsn_pkg::REG_IMAGE_WIDTH, 2);
        write_reg(dsn_pkg::REG_IMAGE_HEIGHT, 2);
        foreach (directed[i]) send_sample(directed[i].sample, directed[i].chk);
        end_burst();
        wait_idle();

        // Focal extremes and clamped sizes on a small steep frame.
        write_reg(dsn_pkg::REG_FOCAL_X, 1);
        write_reg(dsn_pkg::REG_FOCAL_Y, 24'hFFFFFF);
        write_reg(dsn_pkg::REG_IMAGE_WIDTH, 1);
        write_reg(dsn_pkg::REG_IMAGE_HEIGHT, 0);
        send_sample(16'd1, CHK_MODEL);
        send_sample(16'd65535, CHK_MODEL);
        send_sample(16'd40000, CHK_MODEL);
        send_sample(16'd2, CHK_MODEL);
        end_burst();
        wait_idle();

        // A 4x4 frame sent without gaps while the receiver holds off, so the
        // job queue fills and the input stalls.
        write_reg(dsn_pkg::REG_IMAGE_WIDTH, 4);
        write_reg(dsn_pkg::REG_IMAGE_HEIGHT, 4);
        hold_req = 1'b1;
        no_idle = 1'b1;
        repeat (16) send_sample(rand_depth(), CHK_MODEL);
        end_burst();
        no_idle = 1'b0;
        wait_idle();

        // Random frames, mostly complete, some cut short.
        phase = 0;
        while (samples_sent < 130) begin
            w = $urandom_range(2, 8);
            h = $urandom_range(2, 5);
            write_reg(dsn_pkg::REG_IMAGE_WIDTH, w);
            write_reg(dsn_pkg::REG_IMAGE_HEIGHT, h);
            write_reg(dsn_pkg::REG_FOCAL_X, rand_focal());
            write_reg(dsn_pkg::REG_FOCAL_Y, rand_focal());
            no_idle = ($urandom_range(0, 3) == 0);
            if (phase == 2) hold_req = 1'b1;
            n = w * h * $urandom_range(1, 2);
            if ($urandom_range(0, 4) == 0) n = $urandom_range(1, w * h - 1);
            repeat (n) send_sample(rand_depth(), CHK_MODEL);
            end_burst();
            no_idle = 1'b0;
            wait_idle();
            phase++;
        end

        // Widest and tallest clamped sizes, only partly filled.
        write_reg(dsn_pkg::REG_IMAGE_WIDTH, 2047);
        write_reg(dsn_pkg::REG_IMAGE_HEIGHT, 1);
        no_idle = 1'b1;
        repeat (40) send_sample(rand_depth(), CHK_MODEL);
        end_burst();
        no_idle = 1'b0;
        wait_idle();
        write_reg(dsn_pkg::REG_IMAGE_WIDTH, 2);
        write_reg(dsn_pkg::REG_IMAGE_HEIGHT, 1024);
        repeat (40) send_sample(rand_depth(), CHK_MODEL);
        end_burst();
        wait_idle();

        $display("sent %0d depth samples, checked %0d normals (%0d valid, %0d frame ends)",
                 samples_sent, normals_seen, valid_normals, frames_seen);
        $display("sizes from clamped minimum to clamped maximum, focal lengths 1 to max");
        if (errors == 0 && exp_wr == exp_rd)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
